### hdl/pid_pkg.sv
`default_nettype none

package pid_pkg;

  localparam int DataW  = 16;  // measured, setpoint, gains, drive
  localparam int ErrW   = 17;  // setpoint - measured, never wraps
  localparam int DiffW  = 18;  // error - previous error
  localparam int LimW   = 15;  // unsigned limits
  localparam int IdxW   = 3;   // configuration register index
  localparam int TermPW = 25;  // (gain_p * error) >> 8
  localparam int TermIW = 24;  // (gain_i * integral) >> 8
  localparam int TermDW = 26;  // (gain_d * diff) >> 8
  localparam int AccW   = 28;  // sum of the three terms

  localparam logic [LimW-1:0] LimitReset = LimW'(4096);  // 1.0 in Q4.12

  typedef enum logic [IdxW-1:0] {
    RegGainP      = 3'd0,
    RegGainI      = 3'd1,
    RegGainD      = 3'd2,
    RegIntLimit   = 3'd3,
    RegOutLimit   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic        [LimW-1:0]  integral_limit;
    logic        [LimW-1:0]  output_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [DataW-1:0] integ;
    logic signed [DiffW-1:0] diff;
  } err_t;

  typedef struct packed {
    logic signed [TermPW-1:0] p;
    logic signed [TermIW-1:0] i;
    logic signed [TermDW-1:0] d;
  } term_t;

endpackage

`default_nettype wire

### hdl/pid_cfg.sv
`default_nettype none

module pid_cfg (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [pid_pkg::IdxW-1:0]  cfg_index_i,
  input  wire logic [pid_pkg::DataW-1:0] cfg_data_i,
  output pid_pkg::cfg_t                cfg_o
);
  import pid_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegGainP:    cfg_d.gain_p         = cfg_data_i;
        RegGainI:    cfg_d.gain_i         = cfg_data_i;
        RegGainD:    cfg_d.gain_d         = cfg_data_i;
        RegIntLimit: cfg_d.integral_limit = cfg_data_i[LimW-1:0];
        RegOutLimit: cfg_d.output_limit   = cfg_data_i[LimW-1:0];
        default:     cfg_d = cfg_q;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.integral_limit <= LimitReset;
      cfg_q.output_limit   <= LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hdl/pid_err.sv
`default_nettype none

module pid_err (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [2*pid_pkg::DataW-1:0] s_data_i,
  input  wire logic [pid_pkg::LimW-1:0]    integral_limit_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output pid_pkg::err_t                  data_o
);
  import pid_pkg::*;

  logic                    a_valid_q;
  logic signed [DataW-1:0] meas_q, setp_q;
  logic                    b_valid_q;
  err_t                    b_q, b_d;
  logic signed [DataW-1:0] esum_q, esum_d;
  logic signed [ErrW-1:0]  prev_q;

  logic                    b_ready, a_take, s_take;
  logic signed [ErrW-1:0]  err;
  logic signed [DiffW-1:0] acc, lim;

  assign b_ready   = !b_valid_q || ready_i;
  assign a_take    = a_valid_q && b_ready;
  assign s_ready_o = !a_valid_q || b_ready;
  assign s_take    = s_valid_i && s_ready_o;
  assign valid_o   = b_valid_q;
  assign data_o    = b_q;

  always_comb begin
    err = {setp_q[DataW-1], setp_q} - {meas_q[DataW-1], meas_q};
    acc = {{2{esum_q[DataW-1]}}, esum_q} + {err[ErrW-1], err};
    lim = {3'b000, integral_limit_i};
    // clamp the running integral to +/- limit
    if (acc > lim) begin
      esum_d = lim[DataW-1:0];
    end else if (acc < -lim) begin
      esum_d = DataW'(-lim);
    end else begin
      esum_d = acc[DataW-1:0];
    end
    b_d.err   = err;
    b_d.integ = esum_d;
    b_d.diff  = {err[ErrW-1], err} - {prev_q[ErrW-1], prev_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      esum_q    <= '0;
      prev_q    <= '0;
    end else begin
      if (s_take) begin
        a_valid_q <= 1'b1;
      end else if (a_take) begin
        a_valid_q <= 1'b0;
      end
      if (a_take) begin
        b_valid_q <= 1'b1;
        esum_q    <= esum_d;
        prev_q    <= err;
      end else if (ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      meas_q <= s_data_i[DataW-1:0];
      setp_q <= s_data_i[2*DataW-1:DataW];
    end
    if (a_take) begin
      b_q <= b_d;
    end
  end

endmodule

`default_nettype wire

### hdl/pid_mul.sv
`default_nettype none

module pid_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire pid_pkg::err_t data_i,
  input  wire pid_pkg::cfg_t cfg_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output pid_pkg::term_t     data_o
);
  import pid_pkg::*;

  logic          valid_q;
  term_t         term_q, term_d;
  logic          take;
  logic [32:0]   prod_p;
  logic [31:0]   prod_i;
  logic [33:0]   prod_d;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign data_o  = term_q;

  // Sign-extended operands: the low product bits equal the signed product.
  always_comb begin
    prod_p = {{17{cfg_i.gain_p[DataW-1]}}, cfg_i.gain_p}
           * {{16{data_i.err[ErrW-1]}}, data_i.err};
    prod_i = {{16{cfg_i.gain_i[DataW-1]}}, cfg_i.gain_i}
           * {{16{data_i.integ[DataW-1]}}, data_i.integ};
    prod_d = {{18{cfg_i.gain_d[DataW-1]}}, cfg_i.gain_d}
           * {{16{data_i.diff[DiffW-1]}}, data_i.diff};
    // drop the fraction bits: floor of the shift by eight
    term_d.p = prod_p[32:8];
    term_d.i = prod_i[31:8];
    term_d.d = prod_d[33:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      term_q <= term_d;
    end
  end

endmodule

`default_nettype wire

### hdl/pid_sat.sv
`default_nettype none

module pid_sat (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire pid_pkg::term_t          data_i,
  input  wire logic [pid_pkg::LimW-1:0]  output_limit_i,
  output logic                         m_valid_o,
  input  wire logic                    m_ready_i,
  output logic [pid_pkg::DataW-1:0]    m_drive_o,
  output logic                         m_sat_o
);
  import pid_pkg::*;

  logic                    valid_q;
  logic [DataW-1:0]        drive_q, drive_d;
  logic                    sat_q, sat_d;
  logic                    take;
  logic signed [AccW-1:0]  sum, lim;

  assign ready_o   = !valid_q || m_ready_i;
  assign take      = valid_i && ready_o;
  assign m_valid_o = valid_q;
  assign m_drive_o = drive_q;
  assign m_sat_o   = sat_q;

  always_comb begin
    sum = {{(AccW-TermPW){data_i.p[TermPW-1]}}, data_i.p}
        + {{(AccW-TermIW){data_i.i[TermIW-1]}}, data_i.i}
        + {{(AccW-TermDW){data_i.d[TermDW-1]}}, data_i.d};
    lim = {{(AccW-LimW){1'b0}}, output_limit_i};
    sat_d = 1'b1;
    if (sum > lim) begin
      drive_d = lim[DataW-1:0];
    end else if (sum < -lim) begin
      drive_d = DataW'(-lim);
    end else begin
      drive_d = sum[DataW-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

endmodule

`default_nettype wire

### hdl/pid_with_integral_clamp.sv
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] measured, tdata[31:16] setpoint (Q4.12)
// m_axis    out        tdata[15:0] drive (Q4.12), tuser[0] saturated
// cfg       in         cfg_index_i register, cfg_data_i value
//
// One item per cycle sustained while m_axis_tready stays high. An item moves
// through the input register, error/integral register, product register and
// result register. The integral and last error update as an item leaves the
// input register. Reset clears the state and loads the default limits.
// Each stage holds while the stage after it is full and not draining.
`default_nettype none

module pid_with_integral_clamp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,   // measured, setpoint
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // drive
  output logic [0:0]                     m_axis_tuser,   // saturated
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [pid_pkg::IdxW-1:0]  cfg_index_i,
  input  wire logic [pid_pkg::DataW-1:0] cfg_data_i
);
  import pid_pkg::*;

  cfg_t  cfg;
  err_t  err_data;
  term_t term_data;
  logic  err_valid, err_ready;
  logic  term_valid, term_ready;

  pid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pid_err u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_valid_i        (s_axis_tvalid),
    .s_ready_o        (s_axis_tready),
    .s_data_i         (s_axis_tdata),
    .integral_limit_i (cfg.integral_limit),
    .valid_o          (err_valid),
    .ready_i          (err_ready),
    .data_o           (err_data)
  );

  pid_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .data_i  (err_data),
    .cfg_i   (cfg),
    .valid_o (term_valid),
    .ready_i (term_ready),
    .data_o  (term_data)
  );

  pid_sat u_sat (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (term_valid),
    .ready_o        (term_ready),
    .data_i         (term_data),
    .output_limit_i (cfg.output_limit),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_drive_o      (m_axis_tdata),
    .m_sat_o        (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

### hdl/pid_chk.sv
`default_nettype none

module pid_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // items accepted but not yet delivered
  logic [2:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more items in flight than pipeline stages");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 3'd0)
    else $error("result offered with no item in flight");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != 16'h8000)
    else $error("drive outside symmetric range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind pid_with_integral_clamp pid_chk u_pid_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
